// ===== rtl/hvt_pkg.sv =====
`timescale 1ns / 1ps
package hvt_pkg;

  localparam int GrayLevels = 256;
  localparam int QueueDepth = 4;

  localparam logic [1:0] REG_SMOOTHING_WIDTH = 2'd0;
  localparam logic [1:0] REG_SEARCH_MODE     = 2'd1;
  localparam logic [1:0] REG_VALLEY_COUNT    = 2'd2;

  localparam logic MODE_BALANCE = 1'b0;
  localparam logic MODE_PEAK    = 1'b1;

  localparam logic [7:0] SCAN_FIRST = 8'd2;
  localparam logic [7:0] SCAN_LAST  = 8'd253;
  localparam logic [7:0] LEVEL_MAX  = 8'd255;
  localparam logic [7:0] LEVEL_254  = 8'd254;

  typedef struct packed {
    logic [7:0] level;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] smoothing_width;
    logic       search_mode;
    logic [7:0] valley_count;
  } cfg_t;

endpackage

// ===== rtl/histogram_valley_threshold_top.sv =====
`timescale 1ns / 1ps
// Histogram valley threshold.
// Input channel: pixel_value and last_pixel, written with push while full is
// low. A small request queue takes pixels one per cycle; the counting stage
// drains it at one pixel per cycle outside the search, with a read-modify-write
// on the bin memory. The pixel marked last_pixel closes the image and starts
// the search. Result channel: threshold is valid while empty is low and is
// taken by pop. After the last pixel the block smooths the histogram, using
// the bit-serial divider that scales each smoothed bin, then scans for the
// valley with a read step and an evaluate step per gray level. During that
// time pixels of the next image are held in the queue and full rises once it
// fills.
// Configuration: cfg_write with cfg_index 0 (smoothing width), 1 (search
// mode), 2 (valley count); write only while the block is idle.
// Reset clears the histogram, the pixel count, the queue and the result slot
// and restores the register defaults. If the receiver does not pop, the result
// waits in its slot; a following image's search then holds in its final step
// until the slot is free, and its pixels wait in the queue meanwhile.
module histogram_valley_threshold_top import hvt_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_value,
  input  logic       last_pixel,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] threshold,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_width <= 8'd1;
      cfg.search_mode     <= MODE_BALANCE;
      cfg.valley_count    <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SMOOTHING_WIDTH: cfg.smoothing_width <= cfg_data;
        REG_SEARCH_MODE:     cfg.search_mode     <= cfg_data[0];
        REG_VALLEY_COUNT:    cfg.valley_count    <= cfg_data;
        default:             ;
      endcase
    end
  end

  hvt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .last_pixel  (last_pixel),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  hvt_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .threshold (threshold)
  );

endmodule

// ===== rtl/hvt_front.sv =====
`timescale 1ns / 1ps
module hvt_front import hvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_value,
  input  logic       last_pixel,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int PW = $clog2(QueueDepth);

  item_t           slots [QueueDepth];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == (PW+1)'(QueueDepth));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{level: pixel_value, last: last_pixel};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/hvt_div.sv =====
`timescale 1ns / 1ps
module hvt_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [8:0]    divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [8:0]    dvs;
  logic [8:0]    rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [9:0]    rs;
  logic          ge;

  assign rs       = {rem, dvd[DW-1]};
  assign ge       = rs >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 9'(rs - {1'b0, dvs}) : rs[8:0];
        dvd <= {dvd[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/hvt_back.sv =====
`timescale 1ns / 1ps
module hvt_back import hvt_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] threshold
);

  localparam int CB = COUNT_BITS;
  localparam int AW = CB + 8;
  localparam int SW = CB + 11;

  typedef enum logic [3:0] {
    ST_RUN, ST_SM_RD, ST_SM_ACC, ST_SM_DIV, ST_SR_I0, ST_SR_I1, ST_SR_I2,
    ST_SR_RD, ST_SR_EV, ST_EMIT
  } state_t;

  state_t state;

  logic [CB-1:0] hist   [GrayLevels];
  logic [CB-1:0] smooth [GrayLevels];
  logic [GrayLevels-1:0] vld;

  logic [7:0]    ra, rb, sa;
  logic [CB-1:0] rda, rdb, sd;
  logic          rda_v, rdb_v;
  logic [CB-1:0] va, vb;

  logic          s1_valid, s1_last;
  logic [7:0]    s1_level;
  logic          wp_valid;
  logic [7:0]    wp_level;
  logic [CB-1:0] wp_val;
  logic [CB-1:0] cur, inc;
  logic          hist_we;
  logic [CB:0]   pixel_total;

  logic [6:0]    half;
  logic [8:0]    j;
  logic [9:0]    jb;
  logic [8:0]    out_idx;
  logic [AW-1:0] acc, acc_new;
  logic          div_start, div_done;
  logic [AW-1:0] div_q;

  logic [7:0]    k;
  logic [7:0]    x;
  logic [CB-1:0] sp, sc;
  logic signed [SW-1:0] sum, sum_new, gap, gap_abs, best, total_s;
  logic [7:0]    left;
  logic [7:0]    result;
  logic          valley;

  assign va   = rda_v ? rda : '0;
  assign vb   = rdb_v ? rdb : '0;
  assign half = cfg.smoothing_width[7:1];
  assign jb   = {1'b0, j} - {2'b00, half, 1'b1};
  assign out_idx = j - {2'b00, half};

  always_comb begin
    ra = '0;
    rb = '0;
    case (state)
      ST_RUN:   ra = q_item.level;
      ST_SM_RD: begin
        ra = j[7:0];
        rb = jb[7:0];
      end
      ST_SR_I0: begin
        ra = LEVEL_254;
        rb = LEVEL_MAX;
      end
      ST_SR_I1: begin
        ra = 8'd0;
        rb = 8'd1;
      end
      ST_SR_RD: ra = k - 1'b1;
      default:  ra = '0;
    endcase
  end
  assign sa = k;

  always_ff @(posedge clk) begin
    rda   <= hist[ra];
    rdb   <= hist[rb];
    rda_v <= vld[ra];
    rdb_v <= vld[rb];
    sd    <= smooth[sa];
    if (hist_we) hist[s1_level] <= inc;
  end

  // Reads miss a same-cycle write, so the last write is forwarded.
  assign cur     = (wp_valid && wp_level == s1_level) ? wp_val : va;
  assign inc     = (cur == {CB{1'b1}}) ? cur : cur + 1'b1;
  assign hist_we = (state == ST_RUN) && s1_valid;
  assign q_pop   = (state == ST_RUN) && q_valid && !(s1_valid && s1_last);

  always_comb begin
    acc_new = acc;
    if (!j[8]) acc_new = acc_new + AW'(va);
    if (!jb[9]) acc_new = acc_new - AW'(vb);
  end
  assign div_start = (state == ST_SM_ACC) && (j >= {2'b00, half});

  hvt_div #(.DW(AW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_new),
    .divisor  ({1'b0, cfg.smoothing_width} + 9'd1),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (state == ST_SM_DIV && div_done) smooth[out_idx[7:0]] <= div_q[CB-1:0];
  end

  // Window at level x: previous, current and the freshly read next bin.
  assign x        = k - 1'b1;
  assign valley   = (sp >= sc) && (sc < sd);
  assign sum_new  = sum + SW'(va);
  assign total_s  = SW'(pixel_total);
  assign gap      = total_s - (sum_new <<< 1);
  assign gap_abs  = gap[SW-1] ? -gap : gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      s1_valid    <= 1'b0;
      wp_valid    <= 1'b0;
      vld         <= '0;
      pixel_total <= '0;
      empty       <= 1'b1;
    end else begin
      if (state == ST_EMIT && (empty || pop)) empty <= 1'b0;
      else if (pop && !empty) empty <= 1'b1;
      wp_valid <= hist_we;
      if (hist_we) begin
        wp_level      <= s1_level;
        wp_val        <= inc;
        vld[s1_level] <= 1'b1;
        if (pixel_total != {(CB+1){1'b1}}) pixel_total <= pixel_total + 1'b1;
      end
      case (state)
        ST_RUN: begin
          s1_valid <= q_pop;
          s1_level <= q_item.level;
          s1_last  <= q_item.last;
          if (s1_valid && s1_last) begin
            j     <= '0;
            acc   <= '0;
            state <= ST_SM_RD;
          end
        end
        ST_SM_RD: state <= ST_SM_ACC;
        ST_SM_ACC: begin
          acc <= acc_new;
          if (div_start) begin
            state <= ST_SM_DIV;
          end else begin
            j     <= j + 1'b1;
            state <= ST_SM_RD;
          end
        end
        ST_SM_DIV: begin
          if (div_done) begin
            if (out_idx == 9'(LEVEL_MAX)) begin
              state <= ST_SR_I0;
            end else begin
              j     <= j + 1'b1;
              state <= ST_SM_RD;
            end
          end
        end
        ST_SR_I0: state <= ST_SR_I1;
        ST_SR_I1: begin
          sum   <= -(SW'(va) + SW'(vb));
          state <= ST_SR_I2;
        end
        ST_SR_I2: begin
          sum    <= sum + SW'(va) + SW'(vb);
          best   <= total_s;
          left   <= cfg.valley_count;
          result <= '0;
          k      <= '0;
          state  <= ST_SR_RD;
        end
        ST_SR_RD: state <= ST_SR_EV;
        ST_SR_EV: begin
          sp <= sc;
          sc <= sd;
          if (x >= SCAN_FIRST && x <= SCAN_LAST && k != 8'd0) begin
            sum <= sum_new;
            if (valley) begin
              if (cfg.search_mode == MODE_BALANCE) begin
                if (gap_abs < best) begin
                  best   <= gap_abs;
                  result <= x;
                end
              end else if (left != 8'd0) begin
                left <= left - 1'b1;
                if (left == 8'd1) result <= x;
              end
            end
          end
          if (k == LEVEL_254) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_SR_RD;
          end
        end
        ST_EMIT: begin
          if (empty || pop) begin
            threshold   <= result;
            vld         <= '0;
            pixel_total <= '0;
            s1_valid    <= 1'b0;
            state       <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  a_write_only_in_run: assert property (@(posedge clk) disable iff (rst)
    hist_we |-> state == ST_RUN)
    else $error("histogram written outside the counting phase");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(threshold)))
    else $error("waiting result changed before it was taken");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_SM_DIV)
    else $error("divider finished outside the smoothing divide step");

  a_no_pop_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && state == ST_RUN) |-> !q_pop)
    else $error("pixel taken while an image is being closed");

endmodule
